FILE: design/swgs_pkg.sv
// ----------------------------------------------------------------------------
// swgs_pkg
// shared types and constants of the shallow water grid stepper
// ----------------------------------------------------------------------------
`default_nettype none
package swgs_pkg;
  localparam int GRID_DIM_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int GAIN_BITS     = 24;
  localparam int IDX_BITS      = 6;
  localparam int FIELD_BITS    = 32;
  localparam logic [GAIN_BITS-1:0] VEL_GAIN_RST = 24'd80364;
  localparam logic [GAIN_BITS-1:0] HGT_GAIN_RST = 24'd8192;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    REG_VEL_GAIN = 1'b0,
    REG_HGT_GAIN = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_CELL, ST_RD_WAIT, ST_OUT,
    ST_S_RD1, ST_S_RD2, ST_S_VEL, ST_S_VMUL, ST_S_VWR,
    ST_S_RD3, ST_S_RD4, ST_S_HMUL, ST_S_HWR, ST_S_NEXT
  } state_e;

  typedef enum logic [2:0] {
    RD_CENTRE, RD_NORTH, RD_SOUTH, RD_WEST, RD_EAST
  } rdsel_e;

  typedef struct packed {
    logic   clr_wr;
    logic   host_wr;
    logic   host_rd;
    logic   rd_en;
    rdsel_e rd_sel;
    logic   lat_a;
    logic   lat_b;
    logic   vel_calc;
    logic   vel_wr;
    logic   hgt_calc;
    logic   hgt_wr;
    logic   cnt_first;
    logic   cnt_next;
    logic   cap_out;
    logic   zero_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic sweep_done;
    logic in_grid;
  } sts_t;
endpackage
`default_nettype wire

FILE: design/shallow_water_grid_step_unit.sv
// ----------------------------------------------------------------------------
// shallow_water_grid_step_unit
// three square grids of height and velocity, host access and a time step
// ----------------------------------------------------------------------------
// Input beats carry an operation, a cell index and write values; every beat
// gives exactly one output beat. Write and unused beats answer in the cycle
// after they are taken, a read through address, registered memory read and
// result register. A step sweeps the interior cells in place through one
// read port per grid, one scaler per velocity and one for the height. One
// item is worked at a time.
// After reset a clearing pass writes every cell, one a cycle, with input
// stalled; gain writes are taken throughout.
// A stalled output beat holds; the next input is taken while it waits only
// if the output register will be free.
// The saturated output is the sticky flag after the beat's item.
// ----------------------------------------------------------------------------
`default_nettype none
module shallow_water_grid_step_unit #(
  parameter int GRID_DIM  = swgs_pkg::GRID_DIM_DEF,
  parameter int WORD_BITS = swgs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = swgs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             operation_i,
  input  wire logic [swgs_pkg::IDX_BITS-1:0]          row_i,
  input  wire logic [swgs_pkg::IDX_BITS-1:0]          col_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] in_height_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] in_vel_x_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] in_vel_y_i,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]      out_height_o,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]      out_vel_x_o,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]      out_vel_y_o,
  output logic                                        saturated_o,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic                                   cfg_index_i,
  input  wire logic [swgs_pkg::GAIN_BITS-1:0]         cfg_data_i
);
  swgs_pkg::cmd_t cmd;
  swgs_pkg::sts_t sts;
  logic [swgs_pkg::GAIN_BITS-1:0] vgain_q, hgain_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vgain_q <= swgs_pkg::VEL_GAIN_RST;
      hgain_q <= swgs_pkg::HGT_GAIN_RST;
    end else if (cfg_valid) begin
      case (swgs_pkg::reg_e'(cfg_index_i))
        swgs_pkg::REG_VEL_GAIN: vgain_q <= cfg_data_i;
        swgs_pkg::REG_HGT_GAIN: hgain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  swgs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i(operation_i),
    .out_valid, .out_stall, .sts_i(sts), .cmd_o(cmd)
  );

  swgs_dp #(.GRID_DIM(GRID_DIM), .WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .row_i(row_i),
    .col_i(col_i),
    .hgt_i(in_height_i), .vx_i(in_vel_x_i), .vy_i(in_vel_y_i),
    .vgain_i(vgain_q), .hgain_i(hgain_q),
    .out_h_o(out_height_o), .out_vx_o(out_vel_x_o), .out_vy_o(out_vel_y_o),
    .sat_o(saturated_o)
  );
endmodule
`default_nettype wire

FILE: design/swgs_ctrl.sv
// ----------------------------------------------------------------------------
// swgs_ctrl
// sequencer for host access, clearing pass and the grid sweep
// ----------------------------------------------------------------------------
`default_nettype none
module swgs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      op_i,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire swgs_pkg::sts_t  sts_i,
  output swgs_pkg::cmd_t       cmd_o
);
  swgs_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swgs_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel = swgs_pkg::RD_CENTRE;
    in_stall    = 1'b1;
    if (out_valid_q && !out_stall) out_valid_d = 1'b0;
    case (state_q)
      swgs_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = swgs_pkg::ST_IDLE;
      end
      swgs_pkg::ST_IDLE: begin
        in_stall = out_valid_q && out_stall;
        if (in_valid && !in_stall) begin
          case (swgs_pkg::op_e'(op_i))
            swgs_pkg::OP_WRITE: begin
              cmd_o.host_wr  = sts_i.in_grid;
              cmd_o.zero_out = 1'b1;
              out_valid_d    = 1'b1;
            end
            swgs_pkg::OP_STEP: begin
              cmd_o.cnt_first = 1'b1;
              state_d = swgs_pkg::ST_S_RD1;
            end
            swgs_pkg::OP_READ: begin
              cmd_o.host_rd = 1'b1;
              state_d = swgs_pkg::ST_RD_WAIT;
            end
            default: begin
              cmd_o.zero_out = 1'b1;
              out_valid_d    = 1'b1;
            end
          endcase
        end
      end
      swgs_pkg::ST_RD_WAIT: begin
        state_d = swgs_pkg::ST_OUT;
      end
      swgs_pkg::ST_RD_CELL, swgs_pkg::ST_OUT: begin
        cmd_o.cap_out = 1'b1;
        out_valid_d   = 1'b1;
        state_d       = swgs_pkg::ST_IDLE;
      end
      // sweep: north/south then west/east heights, velocities, divergence
      swgs_pkg::ST_S_RD1: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = swgs_pkg::RD_NORTH;
        state_d = swgs_pkg::ST_S_RD2;
      end
      swgs_pkg::ST_S_RD2: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = swgs_pkg::RD_SOUTH;
        cmd_o.lat_a = 1'b1;
        state_d = swgs_pkg::ST_S_VEL;
      end
      swgs_pkg::ST_S_VEL: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = swgs_pkg::RD_WEST;
        cmd_o.lat_b = 1'b1;
        state_d = swgs_pkg::ST_S_VMUL;
      end
      swgs_pkg::ST_S_VMUL: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = swgs_pkg::RD_EAST;
        cmd_o.lat_a = 1'b1;
        state_d = swgs_pkg::ST_S_RD3;
      end
      swgs_pkg::ST_S_RD3: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = swgs_pkg::RD_CENTRE;
        cmd_o.lat_b = 1'b1;
        state_d = swgs_pkg::ST_S_RD4;
      end
      swgs_pkg::ST_S_RD4: begin
        cmd_o.vel_calc = 1'b1;
        state_d = swgs_pkg::ST_S_VWR;
      end
      swgs_pkg::ST_S_VWR: begin
        cmd_o.vel_wr = 1'b1;
        state_d = swgs_pkg::ST_S_HMUL;
      end
      swgs_pkg::ST_S_HMUL: begin
        cmd_o.hgt_calc = 1'b1;
        state_d = swgs_pkg::ST_S_HWR;
      end
      swgs_pkg::ST_S_HWR: begin
        cmd_o.hgt_wr = 1'b1;
        state_d = swgs_pkg::ST_S_NEXT;
      end
      swgs_pkg::ST_S_NEXT: begin
        cmd_o.cnt_next = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.zero_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = swgs_pkg::ST_IDLE;
        end else begin
          state_d = swgs_pkg::ST_S_RD1;
        end
      end
      default: state_d = swgs_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/swgs_dp.sv
// ----------------------------------------------------------------------------
// swgs_dp
// grid memories, scalers and saturation for the sweep
// ----------------------------------------------------------------------------
`default_nettype none
module swgs_dp #(
  parameter int GRID_DIM  = swgs_pkg::GRID_DIM_DEF,
  parameter int WORD_BITS = swgs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = swgs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire swgs_pkg::cmd_t                      cmd_i,
  output swgs_pkg::sts_t                           sts_o,
  input  wire logic [swgs_pkg::IDX_BITS-1:0]       row_i,
  input  wire logic [swgs_pkg::IDX_BITS-1:0]       col_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] hgt_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] vx_i,
  input  wire logic signed [swgs_pkg::FIELD_BITS-1:0] vy_i,
  input  wire logic [swgs_pkg::GAIN_BITS-1:0]      vgain_i,
  input  wire logic [swgs_pkg::GAIN_BITS-1:0]      hgain_i,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]   out_h_o,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]   out_vx_o,
  output logic signed [swgs_pkg::FIELD_BITS-1:0]   out_vy_o,
  output logic                                     sat_o
);
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_DIM);
  localparam int FB    = swgs_pkg::FIELD_BITS;
  localparam int GB    = swgs_pkg::GAIN_BITS;
  localparam int DW    = WORD_BITS + 2;
  localparam int PW    = DW + GB;
  localparam int EW    = WORD_BITS + 4;
  localparam logic signed [EW-1:0] WMAX = EW'((64'sd1 <<< (WORD_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] WMIN = -WMAX - EW'(1);
  localparam logic [PW-1:0] CAP = PW'(1) << (WORD_BITS + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1) << FRAC_BITS;

  logic signed [WORD_BITS-1:0] hmem [CELLS];
  logic signed [WORD_BITS-1:0] xmem [CELLS];
  logic signed [WORD_BITS-1:0] ymem [CELLS];
  logic signed [WORD_BITS-1:0] hrd_q, xrd_q, yrd_q;

  logic [AW:0]   clr_q;
  logic [CW-1:0] i_q, j_q;
  logic          sat_q;
  logic signed [WORD_BITS-1:0] ha_q, hb_q, hc_q, hd_q;
  logic signed [WORD_BITS-1:0] xa_q, xb_q, ya_q, yb_q;
  logic signed [WORD_BITS-1:0] vx_q, vy_q, hn_q;
  logic [1:0]    lat_cnt_q;
  logic signed [FB-1:0] oh_q, ox_q, oy_q;

  function automatic logic signed [WORD_BITS-1:0] sat_in(input logic signed [FB-1:0] v);
    logic signed [EW+FB-1:0] e;
    e = (EW+FB)'(v);
    if (e > (EW+FB)'(WMAX)) return WMAX[WORD_BITS-1:0];
    if (e < (EW+FB)'(WMIN)) return WMIN[WORD_BITS-1:0];
    return e[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [FB-1:0] sat_out(input logic signed [WORD_BITS-1:0] v);
    logic signed [EW+FB-1:0] e;
    e = (EW+FB)'(v);
    if (e > (EW+FB)'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (e < -(EW+FB)'(33'sh0_8000_0000)) return 32'sh8000_0000;
    return e[FB-1:0];
  endfunction

  function automatic logic signed [EW-1:0] scale(input logic [GB-1:0] g,
                                                  input logic signed [DW-1:0] d);
    logic [DW-1:0] mag;
    logic [PW-1:0] p, r;
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    p = PW'(mag) * PW'(g) + HALF;
    r = p >> FRAC_BITS;
    if (r > CAP) r = CAP;
    return d[DW-1] ? -EW'(r) : EW'(r);
  endfunction

  logic [AW-1:0] c, addr;
  assign c = AW'(i_q) * AW'(GRID_DIM) + AW'(j_q);

  always_comb begin
    case (cmd_i.rd_sel)
      swgs_pkg::RD_NORTH: addr = c + AW'(GRID_DIM);
      swgs_pkg::RD_SOUTH: addr = c - AW'(GRID_DIM);
      swgs_pkg::RD_WEST:  addr = c - AW'(1);
      swgs_pkg::RD_EAST:  addr = c + AW'(1);
      default:            addr = c;
    endcase
    if (cmd_i.host_rd) addr = AW'(row_i) * AW'(GRID_DIM) + AW'(col_i);
  end

  logic [AW-1:0] waddr;
  logic [AW-1:0] haddr;
  assign haddr = AW'(row_i) * AW'(GRID_DIM) + AW'(col_i);
  always_comb begin
    waddr = c;
    if (cmd_i.clr_wr) waddr = clr_q[AW-1:0];
    else if (cmd_i.host_wr) waddr = haddr;
  end

  // memories: one write, one read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.host_wr || cmd_i.hgt_wr)
      hmem[waddr] <= cmd_i.clr_wr ? ONE : (cmd_i.host_wr ? sat_in(hgt_i) : hn_q);
    if (cmd_i.clr_wr || cmd_i.host_wr || cmd_i.vel_wr)
      xmem[waddr] <= cmd_i.clr_wr ? '0 : (cmd_i.host_wr ? sat_in(vx_i) : vx_q);
    if (cmd_i.clr_wr || cmd_i.host_wr || cmd_i.vel_wr)
      ymem[waddr] <= cmd_i.clr_wr ? '0 : (cmd_i.host_wr ? sat_in(vy_i) : vy_q);
    if (cmd_i.rd_en || cmd_i.host_rd) begin
      hrd_q <= hmem[addr];
      xrd_q <= xmem[addr];
      yrd_q <= ymem[addr];
    end
  end

  // neighbour capture; read data arrives in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      if (lat_cnt_q == 2'd0) begin ha_q <= hrd_q; xa_q <= xrd_q; end
      else begin hc_q <= hrd_q; ya_q <= yrd_q; end
    end
    if (cmd_i.lat_b) begin
      if (lat_cnt_q == 2'd1) begin hb_q <= hrd_q; xb_q <= xrd_q; end
      else begin hd_q <= hrd_q; yb_q <= yrd_q; end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lat_cnt_q <= '0;
    else if (cmd_i.cnt_first || cmd_i.cnt_next) lat_cnt_q <= '0;
    else if (cmd_i.lat_a || cmd_i.lat_b) lat_cnt_q <= lat_cnt_q + 2'd1;
  end

  logic signed [EW-1:0] nvx, nvy, nh;
  logic signed [DW-1:0] dhx, dhy, dv;
  logic sat_vx, sat_vy, sat_h;
  assign dhx = DW'(ha_q) - DW'(hb_q);
  assign dhy = DW'(hd_q) - DW'(hc_q);
  assign nvx = EW'(xrd_q) - scale(vgain_i, dhx);
  assign nvy = EW'(yrd_q) - scale(vgain_i, dhy);
  // divergence uses the neighbour velocities captured before this cell's velocity write
  assign dv  = (DW'(xa_q) - DW'(xb_q)) + (DW'(yb_q) - DW'(ya_q));
  assign nh  = EW'(hn_q) - scale(hgain_i, dv);
  assign sat_vx = (nvx > WMAX) || (nvx < WMIN);
  assign sat_vy = (nvy > WMAX) || (nvy < WMIN);
  assign sat_h  = (nh > WMAX) || (nh < WMIN);

  always_ff @(posedge clk_i) begin
    if (cmd_i.vel_calc) begin
      vx_q <= sat_vx ? (nvx > WMAX ? WMAX[WORD_BITS-1:0] : WMIN[WORD_BITS-1:0])
                     : nvx[WORD_BITS-1:0];
      vy_q <= sat_vy ? (nvy > WMAX ? WMAX[WORD_BITS-1:0] : WMIN[WORD_BITS-1:0])
                     : nvy[WORD_BITS-1:0];
    end
    if (cmd_i.hgt_calc)
      hn_q <= sat_h ? (nh > WMAX ? WMAX[WORD_BITS-1:0] : WMIN[WORD_BITS-1:0])
                    : nh[WORD_BITS-1:0];
    else if (cmd_i.vel_calc)
      hn_q <= hrd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      i_q   <= CW'(1);
      j_q   <= CW'(1);
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + (AW+1)'(1);
      if (cmd_i.cnt_first) begin
        i_q <= CW'(1);
        j_q <= CW'(1);
      end else if (cmd_i.cnt_next) begin
        if (j_q == CW'(GRID_DIM - 2)) begin
          j_q <= CW'(1);
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
      if (cmd_i.vel_calc && (sat_vx || sat_vy)) sat_q <= 1'b1;
      if (cmd_i.hgt_calc && sat_h) sat_q <= 1'b1;
    end
  end

  logic in_grid;
  assign in_grid = (32'(row_i) < 32'(GRID_DIM)) && (32'(col_i) < 32'(GRID_DIM));
  logic rd_inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.host_rd) rd_inside_q <= in_grid;
    if (cmd_i.zero_out) begin
      oh_q <= '0; ox_q <= '0; oy_q <= '0;
    end else if (cmd_i.cap_out) begin
      oh_q <= rd_inside_q ? sat_out(hrd_q) : '0;
      ox_q <= rd_inside_q ? sat_out(xrd_q) : '0;
      oy_q <= rd_inside_q ? sat_out(yrd_q) : '0;
    end
  end

  assign out_h_o  = oh_q;
  assign out_vx_o = ox_q;
  assign out_vy_o = oy_q;
  assign sat_o    = sat_q;
  assign sts_o.clr_done   = cmd_i.clr_wr && (clr_q == (AW+1)'(CELLS - 1));
  assign sts_o.sweep_done = (i_q == CW'(GRID_DIM - 2)) && (j_q == CW'(GRID_DIM - 2));
  assign sts_o.in_grid    = in_grid;
endmodule
`default_nettype wire

FILE: design/swgs_checker.sv
// ----------------------------------------------------------------------------
// swgs_checker
// port-level checks of the grid stepper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module swgs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic saturated_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("output beat dropped");
  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |=> saturated_o) else $error("saturation flag cleared");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |-> in_stall) else $error("input taken while output full");
endmodule
bind shallow_water_grid_step_unit swgs_checker u_chk (.*);
`default_nettype wire
